>>> rtl/pcq_pkg.sv
// Shared types and codes for the point-to-capsule query block.
`default_nettype none

package pcq_pkg;

    // Width of the configuration register index.
    localparam int CFG_IDX_W = 3;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_START_X = 3'd0,
        REG_START_Y = 3'd1,
        REG_START_Z = 3'd2,
        REG_END_X   = 3'd3,
        REG_END_Y   = 3'd4,
        REG_END_Z   = 3'd5,
        REG_RADIUS  = 3'd6
    } pcq_reg_t;

    // Per-request status flags that ride along with the data path.
    typedef struct packed {
        logic       in_cap;
        logic       dzero;
        logic       overlap;
        logic [2:0] neg;
    } pcq_flags_t;

endpackage

`default_nettype wire

>>> rtl/point_capsule_query.sv
// Top level of the point and sphere against capsule distance query.
//
//  Channel  | Direction | Contents
//  ---------+-----------+----------------------------------------------------
//  s_axis   | in        | one query request: point x, y, z and sphere radius
//  m_axis   | out       | nearest capsule point, surface gap and two flags
//  cfg      | in        | write of a segment endpoint or the capsule radius
//
// A new request can be taken in every cycle unless a finished result waits at
// the output. The pipeline is built from the bit-per-stage projection divider,
// the square root pipe of COORD_WIDTH+1 stages and the quotient pipe of
// COORD_WIDTH-1 stages. Reset clears every valid bit and loads the default
// capsule (a unit half segment on y with radius one half). When the output
// holds a result that is not taken, the whole pipeline freezes in place, so
// nothing is lost or repeated.
`default_nettype none

module point_capsule_query #(
    parameter int FRAC_BITS   = 16,
    parameter int COORD_WIDTH = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // point_x, point_y, point_z, query_radius, then zero fill
    input  logic [((4*COORD_WIDTH-1)+7)/8*8-1:0] s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // near_x, near_y, near_z, surface_gap, inside_res, sphere_overlaps, then zero fill
    output logic [((4*COORD_WIDTH+1)+7)/8*8-1:0] m_tdata,
    input  logic                            cfg_we,
    input  logic [pcq_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [COORD_WIDTH-1:0]          cfg_data
);

    localparam int W      = COORD_WIDTH;
    localparam int F      = FRAC_BITS;
    localparam int RB     = W + 1;
    localparam int OUT_DW = ((4*W+1)+7)/8*8;
    localparam int FL_W   = $bits(pcq_pkg::pcq_flags_t);
    localparam int SQ_SW  = 3*W + 6*W + (W-1) + FL_W;
    localparam int DV_SW  = 3*W + (W-1) + FL_W;

    // Capsule configuration.
    logic signed [W-1:0] a_reg [3];
    logic signed [W-1:0] b_reg [3];
    logic [W-2:0]        radius_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_reg[0]   <= '0;
            a_reg[1]   <= {W{1'b0}} - (W'(1) << F);
            a_reg[2]   <= '0;
            b_reg[0]   <= '0;
            b_reg[1]   <= W'(1) << F;
            b_reg[2]   <= '0;
            radius_reg <= (W-1)'(1) << (F-1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                pcq_pkg::REG_START_X: a_reg[0]   <= cfg_data;
                pcq_pkg::REG_START_Y: a_reg[1]   <= cfg_data;
                pcq_pkg::REG_START_Z: a_reg[2]   <= cfg_data;
                pcq_pkg::REG_END_X:   b_reg[0]   <= cfg_data;
                pcq_pkg::REG_END_Y:   b_reg[1]   <= cfg_data;
                pcq_pkg::REG_END_Z:   b_reg[2]   <= cfg_data;
                pcq_pkg::REG_RADIUS:  radius_reg <= cfg_data[W-2:0];
                default:              ;
            endcase
        end
    end

    // The pipeline moves as one; it only halts when a finished result waits.
    logic en;
    logic out_valid_reg;

    assign en       = !out_valid_reg || m_tready;
    assign s_tready = en;

    logic signed [W-1:0] pt [3];
    logic [W-2:0]        s_in;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            pt[i] = s_tdata[i*W +: W];
        end
        s_in = s_tdata[3*W +: W-1];
    end

    // Projection, segment point and squared distance.
    logic                 pr_valid;
    logic [2*RB-1:0]      pr_dsq;
    logic signed [W-1:0]  pr_seg [3];
    logic [2*W-1:0]       pr_nm  [3];
    pcq_pkg::pcq_flags_t  pr_flags;
    logic [W-2:0]         pr_s;

    pcq_project #(
        .W      (W),
        .F      (F),
        .SIDE_W (W-1)
    ) u_project (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (s_tvalid),
        .pt       (pt),
        .a        (a_reg),
        .b        (b_reg),
        .r        (radius_reg),
        .side_in  (s_in),
        .out_valid(pr_valid),
        .dsq      (pr_dsq),
        .seg      (pr_seg),
        .nm       (pr_nm),
        .flags    (pr_flags),
        .side_out (pr_s)
    );

    // Distance from the square root pipe; the other values ride alongside.
    logic [SQ_SW-1:0] sq_side_in;
    logic [SQ_SW-1:0] sq_side_out;
    logic             sq_valid;
    logic [RB-1:0]    dist_val;

    assign sq_side_in = {pr_s, pr_flags, pr_nm[2], pr_nm[1], pr_nm[0],
                         pr_seg[2], pr_seg[1], pr_seg[0]};

    pcq_sqrt #(
        .RB     (RB),
        .SIDE_W (SQ_SW)
    ) u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (pr_valid),
        .n        (pr_dsq),
        .side_in  (sq_side_in),
        .out_valid(sq_valid),
        .root     (dist_val),
        .side_out (sq_side_out)
    );

    logic [3*W-1:0]      sq_seg;
    logic [2*W-1:0]      sq_nm [3];
    pcq_pkg::pcq_flags_t sq_flags;
    logic [W-2:0]        sq_s;
    logic [RB-1:0]       gap_raw;
    logic [W-2:0]        gap_sat;
    pcq_pkg::pcq_flags_t dv_flags_in;

    // Surface gap is the distance beyond the radius; the overlap test uses
    // the gap before it is clamped.
    always_comb
    begin
        sq_seg   = sq_side_out[0 +: 3*W];
        for (int i = 0; i < 3; i++)
        begin
            sq_nm[i] = sq_side_out[3*W + i*2*W +: 2*W];
        end
        sq_flags = sq_side_out[9*W +: FL_W];
        sq_s     = sq_side_out[9*W + FL_W +: W-1];
        gap_raw  = (dist_val > {2'b00, radius_reg}) ? dist_val - {2'b00, radius_reg} : '0;
        gap_sat  = (gap_raw > {2'b00, {(W-1){1'b1}}}) ? {(W-1){1'b1}} : gap_raw[W-2:0];
        dv_flags_in         = sq_flags;
        dv_flags_in.dzero   = dist_val == '0;
        dv_flags_in.overlap = gap_raw <= {2'b00, sq_s};
    end

    // Push-out length along each axis: |dl| * r / distance.
    logic [DV_SW-1:0] dv_side_in;
    logic [DV_SW-1:0] dv_side_out;
    logic             dv_valid;
    logic [W-2:0]     quo [3];

    assign dv_side_in = {dv_flags_in, gap_sat, sq_seg};

    pcq_divide #(
        .W      (W),
        .SIDE_W (DV_SW)
    ) u_divide (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (sq_valid),
        .nm       (sq_nm),
        .d        (dist_val),
        .side_in  (dv_side_in),
        .out_valid(dv_valid),
        .q        (quo),
        .side_out (dv_side_out)
    );

    pcq_pkg::pcq_flags_t dv_flags;
    logic signed [W-1:0] dv_seg  [3];
    logic signed [W:0]   qx      [3];
    logic signed [W:0]   sum     [3];
    logic signed [W-1:0] near_nx [3];
    logic [W-2:0]        dv_gap;

    // Inside the capsule, or exactly on the segment, the segment point is the
    // answer; otherwise the segment point moves towards the query by the radius.
    always_comb
    begin
        dv_flags = dv_side_out[3*W + (W-1) +: FL_W];
        dv_gap   = dv_side_out[3*W +: W-1];
        for (int i = 0; i < 3; i++)
        begin
            dv_seg[i] = dv_side_out[i*W +: W];
            qx[i]     = $signed({2'b00, quo[i]});
            sum[i]    = (W+1)'(dv_seg[i]) + (dv_flags.neg[i] ? -qx[i] : qx[i]);
            if (dv_flags.in_cap || dv_flags.dzero)
            begin
                near_nx[i] = dv_seg[i];
            end
            else if (sum[i][W] != sum[i][W-1])
            begin
                near_nx[i] = sum[i][W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
            end
            else
            begin
                near_nx[i] = sum[i][W-1:0];
            end
        end
    end

    // Output register.
    logic signed [W-1:0] near_reg [3];
    logic [W-2:0]        gap_reg;
    logic                inside_reg;
    logic                overlap_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= dv_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                near_reg[i] <= near_nx[i];
            end
            gap_reg     <= dv_gap;
            inside_reg  <= dv_flags.in_cap;
            overlap_reg <= dv_flags.overlap;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_DW'({overlap_reg, inside_reg, gap_reg,
                               near_reg[2], near_reg[1], near_reg[0]});

    // A point inside the capsule has no gap to its surface.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && inside_reg |-> gap_reg == '0)
        else $error("inside result with a nonzero surface gap");

    // Zero gap never exceeds a sphere radius, so inside always overlaps.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && inside_reg |-> overlap_reg)
        else $error("inside result without sphere overlap");

    // A result that is not taken stays in the output register unchanged.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(gap_reg) && $stable(inside_reg))
        else $error("stalled result changed or vanished");

    // While stalled, the front of the pipeline takes no new request.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("request accepted while the pipeline is frozen");

endmodule

`default_nettype wire

>>> rtl/pcq_project.sv
// Front pipeline: projection onto the segment, segment point and squared distance.
`default_nettype none

module pcq_project #(
    parameter int W      = 32,
    parameter int F      = 16,
    parameter int SIDE_W = 31
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     en,
    input  logic                     in_valid,
    input  logic signed [W-1:0]      pt [3],
    input  logic signed [W-1:0]      a [3],
    input  logic signed [W-1:0]      b [3],
    input  logic        [W-2:0]      r,
    input  logic        [SIDE_W-1:0] side_in,
    output logic                     out_valid,
    output logic        [2*W+1:0]    dsq,
    output logic signed [W-1:0]      seg [3],
    output logic        [2*W-1:0]    nm [3],
    output pcq_pkg::pcq_flags_t      flags,
    output logic        [SIDE_W-1:0] side_out
);

    localparam int AW    = W + 1;
    localparam int PW    = 2 * AW;
    localparam int NW    = PW + 2;
    localparam int TW    = F + 1;
    localparam int MW    = AW + TW + 1;
    localparam int SQW   = 2 * AW;
    localparam int SM    = F + 3;
    localparam int DEPTH = F + 7;

    logic                    valid_reg [DEPTH];
    logic [SIDE_W-1:0]       side_reg  [DEPTH];
    logic signed [AW-1:0]    pa_reg    [SM+1][3];
    logic signed [PW-1:0]    pn_reg    [3];
    logic signed [PW-1:0]    pd_reg    [3];
    logic [NW-1:0]           rem_reg   [F+1];
    logic [NW-1:0]           den_reg   [F+1];
    logic [F-1:0]            quo_reg   [F+1];
    logic                    zero_reg  [F+1];
    logic                    one_reg   [F+1];
    logic signed [MW-1:0]    offp_reg  [3];
    logic signed [W-1:0]     seg_s_reg [3];
    logic signed [AW-1:0]    dl_reg    [3];
    logic signed [W-1:0]     seg_q_reg [3];
    logic [SQW-1:0]          sq_reg    [3];
    logic [2*W-1:0]          nm_q_reg  [3];
    logic [2*W-3:0]          rsq_reg;
    logic [2:0]              neg_q_reg;
    logic [SQW-1:0]          dsq_reg;
    logic                    inside_reg;
    logic signed [W-1:0]     seg_d_reg [3];
    logic [2*W-1:0]          nm_d_reg  [3];
    logic [2:0]              neg_d_reg;

    logic signed [AW-1:0]    ab      [3];
    logic signed [AW-1:0]    pa_next [3];
    logic signed [NW-1:0]    num_sum;
    logic signed [NW-1:0]    den_sum;
    logic [NW:0]             shifted [F+1];
    logic                    ge      [F+1];
    logic [NW-1:0]           rem_nxt [F+1];
    logic [TW-1:0]           t_val;
    logic signed [AW-1:0]    off     [3];
    logic [AW-1:0]           mg      [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            ab[i]      = AW'(b[i]) - AW'(a[i]);
            pa_next[i] = AW'(pt[i]) - AW'(a[i]);
        end
        num_sum = NW'(pn_reg[0]) + NW'(pn_reg[1]) + NW'(pn_reg[2]);
        den_sum = NW'(pd_reg[0]) + NW'(pd_reg[1]) + NW'(pd_reg[2]);
        shifted[0] = '0;
        ge[0]      = 1'b0;
        rem_nxt[0] = '0;
        for (int j = 1; j <= F; j++)
        begin
            shifted[j] = {rem_reg[j-1], 1'b0};
            ge[j]      = shifted[j] >= {1'b0, den_reg[j-1]};
            rem_nxt[j] = ge[j] ? NW'(shifted[j] - {1'b0, den_reg[j-1]}) : shifted[j][NW-1:0];
        end
        if (zero_reg[F])
        begin
            t_val = '0;
        end
        else if (one_reg[F])
        begin
            t_val = TW'(1) << F;
        end
        else
        begin
            t_val = {1'b0, quo_reg[F]};
        end
        for (int i = 0; i < 3; i++)
        begin
            off[i] = AW'(offp_reg[i] >>> F);
            mg[i]  = dl_reg[i][AW-1] ? AW'(-dl_reg[i]) : AW'(dl_reg[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < DEPTH; s++)
            begin
                valid_reg[s] <= 1'b0;
            end
        end
        else if (en)
        begin
            valid_reg[0] <= in_valid;
            for (int s = 1; s < DEPTH; s++)
            begin
                valid_reg[s] <= valid_reg[s-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= side_in;
            for (int s = 1; s < DEPTH; s++)
            begin
                side_reg[s] <= side_reg[s-1];
            end
            for (int i = 0; i < 3; i++)
            begin
                pa_reg[0][i] <= pa_next[i];
                for (int s = 1; s <= SM; s++)
                begin
                    pa_reg[s][i] <= pa_reg[s-1][i];
                end
                pn_reg[i]    <= pa_reg[0][i] * ab[i];
                pd_reg[i]    <= ab[i] * ab[i];
                offp_reg[i]  <= ab[i] * $signed({1'b0, t_val});
                seg_s_reg[i] <= a[i] + W'(off[i]);
                dl_reg[i]    <= pa_reg[SM][i] - off[i];
                seg_q_reg[i] <= seg_s_reg[i];
                sq_reg[i]    <= mg[i] * mg[i];
                nm_q_reg[i]  <= mg[i] * r;
                seg_d_reg[i] <= seg_q_reg[i];
                nm_d_reg[i]  <= nm_q_reg[i];
                neg_q_reg[i] <= dl_reg[i][AW-1];
            end
            rem_reg[0]  <= num_sum[NW-1:0];
            den_reg[0]  <= den_sum[NW-1:0];
            quo_reg[0]  <= '0;
            zero_reg[0] <= num_sum <= 0;
            one_reg[0]  <= num_sum >= den_sum;
            for (int j = 1; j <= F; j++)
            begin
                rem_reg[j]  <= rem_nxt[j];
                den_reg[j]  <= den_reg[j-1];
                quo_reg[j]  <= {quo_reg[j-1][F-2:0], ge[j]};
                zero_reg[j] <= zero_reg[j-1];
                one_reg[j]  <= one_reg[j-1];
            end
            rsq_reg    <= r * r;
            dsq_reg    <= SQW'(sq_reg[0]) + SQW'(sq_reg[1]) + SQW'(sq_reg[2]);
            inside_reg <= (SQW'(sq_reg[0]) + SQW'(sq_reg[1]) + SQW'(sq_reg[2]))
                          <= SQW'(rsq_reg);
            neg_d_reg  <= neg_q_reg;
        end
    end

    assign out_valid     = valid_reg[DEPTH-1];
    assign side_out      = side_reg[DEPTH-1];
    assign dsq           = dsq_reg;
    assign flags.in_cap  = inside_reg;
    assign flags.dzero   = 1'b0;
    assign flags.overlap = 1'b0;
    assign flags.neg     = neg_d_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            seg[i] = seg_d_reg[i];
            nm[i]  = nm_d_reg[i];
        end
    end

endmodule

`default_nettype wire

>>> rtl/pcq_sqrt.sv
// Pipelined integer square root, one result bit per stage.
`default_nettype none

module pcq_sqrt #(
    parameter int RB     = 33,
    parameter int SIDE_W = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [2*RB-1:0]   n,
    input  logic [SIDE_W-1:0] side_in,
    output logic              out_valid,
    output logic [RB-1:0]     root,
    output logic [SIDE_W-1:0] side_out
);

    logic              valid_reg [RB+1];
    logic [SIDE_W-1:0] side_reg  [RB+1];
    logic [RB+1:0]     rem_reg   [RB+1];
    logic [RB-1:0]     root_reg  [RB+1];
    logic [2*RB-1:0]   rest_reg  [RB+1];

    logic [RB+3:0]     rw    [RB+1];
    logic [RB+3:0]     trial [RB+1];
    logic              ge    [RB+1];

    always_comb
    begin
        rw[0]    = '0;
        trial[0] = '0;
        ge[0]    = 1'b0;
        for (int j = 1; j <= RB; j++)
        begin
            rw[j]    = {rem_reg[j-1], rest_reg[j-1][2*RB-1 -: 2]};
            trial[j] = {2'b00, root_reg[j-1], 2'b01};
            ge[j]    = rw[j] >= trial[j];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j <= RB; j++)
            begin
                valid_reg[j] <= 1'b0;
            end
        end
        else if (en)
        begin
            valid_reg[0] <= in_valid;
            for (int j = 1; j <= RB; j++)
            begin
                valid_reg[j] <= valid_reg[j-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= side_in;
            rem_reg[0]  <= '0;
            root_reg[0] <= '0;
            rest_reg[0] <= n;
            for (int j = 1; j <= RB; j++)
            begin
                side_reg[j] <= side_reg[j-1];
                rem_reg[j]  <= ge[j] ? (RB+2)'(rw[j] - trial[j]) : rw[j][RB+1:0];
                root_reg[j] <= {root_reg[j-1][RB-2:0], ge[j]};
                rest_reg[j] <= {rest_reg[j-1][2*RB-3:0], 2'b00};
            end
        end
    end

    assign out_valid = valid_reg[RB];
    assign root      = root_reg[RB];
    assign side_out  = side_reg[RB];

endmodule

`default_nettype wire

>>> rtl/pcq_divide.sv
// Three-lane pipelined divider sharing one divisor, one quotient bit per stage.
`default_nettype none

module pcq_divide #(
    parameter int W      = 32,
    parameter int SIDE_W = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [2*W-1:0]    nm [3],
    input  logic [W:0]        d,
    input  logic [SIDE_W-1:0] side_in,
    output logic              out_valid,
    output logic [W-2:0]      q [3],
    output logic [SIDE_W-1:0] side_out
);

    localparam int RB = W + 1;
    localparam int QB = W - 1;

    logic              valid_reg [QB+1];
    logic [SIDE_W-1:0] side_reg  [QB+1];
    logic [RB-1:0]     d_reg     [QB+1];
    logic [RB-1:0]     rem_reg   [QB+1][3];
    logic [QB-1:0]     low_reg   [QB+1][3];
    logic [QB-1:0]     quo_reg   [QB+1][3];

    logic [RB:0]       rw [QB+1][3];
    logic              ge [QB+1][3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            rw[0][i] = '0;
            ge[0][i] = 1'b0;
            for (int j = 1; j <= QB; j++)
            begin
                rw[j][i] = {rem_reg[j-1][i], low_reg[j-1][i][QB-1]};
                ge[j][i] = rw[j][i] >= {1'b0, d_reg[j-1]};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j <= QB; j++)
            begin
                valid_reg[j] <= 1'b0;
            end
        end
        else if (en)
        begin
            valid_reg[0] <= in_valid;
            for (int j = 1; j <= QB; j++)
            begin
                valid_reg[j] <= valid_reg[j-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= side_in;
            d_reg[0]    <= d;
            for (int i = 0; i < 3; i++)
            begin
                rem_reg[0][i] <= nm[i][2*W-1:QB];
                low_reg[0][i] <= nm[i][QB-1:0];
                quo_reg[0][i] <= '0;
            end
            for (int j = 1; j <= QB; j++)
            begin
                side_reg[j] <= side_reg[j-1];
                d_reg[j]    <= d_reg[j-1];
                for (int i = 0; i < 3; i++)
                begin
                    rem_reg[j][i] <= ge[j][i] ? RB'(rw[j][i] - {1'b0, d_reg[j-1]})
                                              : rw[j][i][RB-1:0];
                    low_reg[j][i] <= {low_reg[j-1][i][QB-2:0], 1'b0};
                    quo_reg[j][i] <= {quo_reg[j-1][i][QB-2:0], ge[j][i]};
                end
            end
        end
    end

    assign out_valid = valid_reg[QB];
    assign side_out  = side_reg[QB];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            q[i] = quo_reg[QB][i];
        end
    end

endmodule

`default_nettype wire
